@@ sv/quaternion_rotation_unit_top_assert.svh @@
// assertion macros for the quaternion rotation unit
// expects clk and rst_n in the scope of the module that uses them
`ifndef QUATERNION_ROTATION_UNIT_TOP_ASSERT_SVH
`define QUATERNION_ROTATION_UNIT_TOP_ASSERT_SVH

// same-cycle implication
`define QRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/qru_pkg.sv @@
// shared types, constants and product tables of the quaternion rotation unit
// no dependencies
package qru_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 28;

  localparam int PROD_W     = 2 * WORD_BITS;
  localparam int ACC_W      = 2 * WORD_BITS + 3;
  localparam int MUL_LAT    = 3;
  localparam int SQRT_STEPS = WORD_BITS + 1;
  localparam int DIV_STEPS  = FRACTION_BITS + 1;
  localparam int NORM_LAT   = 3 + SQRT_STEPS + DIV_STEPS + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef word_t [3:0] quat_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // component index of the scalar part
  localparam logic [1:0] IDX_W = 2'd3;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_CONJ = 2'd1,
    OP_NORM = 2'd2,
    OP_ROT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    quat_t q;
    logic  sat;
  } res_t;

  // hamilton product terms: component c sums p[TERM_P] * q[TERM_Q], negated by TERM_NEG
  localparam logic [1:0] TERM_P [4][4] = '{
    '{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd3, 2'd0, 2'd1, 2'd2}};
  localparam logic [1:0] TERM_Q [4][4] = '{
    '{2'd0, 2'd3, 2'd2, 2'd1}, '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3}, '{2'd3, 2'd0, 2'd1, 2'd2}};
  localparam logic TERM_NEG [4][4] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1}, '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b1, 1'b1}};

endpackage

@@ sv/qru_ifs.sv @@
// valid/ready channel interfaces for input items and result items
// depends on qru_pkg
interface qru_in_if import qru_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  word_t      a_x;
  word_t      a_y;
  word_t      a_z;
  word_t      a_w;
  word_t      b_x;
  word_t      b_y;
  word_t      b_z;
  word_t      b_w;

  modport source (output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink (input valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                output ready);
endinterface

interface qru_out_if import qru_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      r_x;
  word_t      r_y;
  word_t      r_z;
  word_t      r_w;
  logic [1:0] status;

  modport source (output valid, r_x, r_y, r_z, r_w, status, input ready);
  modport sink (input valid, r_x, r_y, r_z, r_w, status, output ready);
endinterface

@@ sv/qru_mul.sv @@
// three-stage quaternion product: products, pair sums, round and saturate
// depends on qru_pkg
module qru_mul import qru_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  quat_t      p,
  input  quat_t      q,
  input  logic       conj_q,
  output quat_t      r,
  output logic [3:0] sat
);

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRACTION_BITS - 1);

  logic signed [PROD_W-1:0] prod_r [4][4];
  logic                     ng_r   [4][4];
  logic signed [PROD_W+1:0] lo_r   [4];
  logic signed [PROD_W+1:0] hi_r   [4];
  quat_t                    r_r;
  logic [3:0]               sat_r;

  function automatic logic signed [PROD_W:0] term(logic signed [PROD_W-1:0] v, logic ng);
    logic signed [PROD_W:0] e;
    e = (PROD_W+1)'(v);
    return ng ? -e : e;
  endfunction

  for (genvar c = 0; c < 4; c++) begin : g_comp
    for (genvar t = 0; t < 4; t++) begin : g_term
      always_ff @(posedge clk) begin
        if (en) begin
          prod_r[c][t] <= p[TERM_P[c][t]] * q[TERM_Q[c][t]];
          ng_r[c][t]   <= TERM_NEG[c][t] ^ (conj_q && (TERM_Q[c][t] != IDX_W));
        end
      end
    end

    logic signed [ACC_W-1:0]                      acc;
    logic [ACC_W-FRACTION_BITS-WORD_BITS:0]       top;

    always_comb begin
      acc = ACC_W'(lo_r[c]) + ACC_W'(hi_r[c]) + HALF;
      top = acc[ACC_W-1:FRACTION_BITS+WORD_BITS-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lo_r[c] <= (PROD_W+2)'(term(prod_r[c][0], ng_r[c][0]))
                 + (PROD_W+2)'(term(prod_r[c][1], ng_r[c][1]));
        hi_r[c] <= (PROD_W+2)'(term(prod_r[c][2], ng_r[c][2]))
                 + (PROD_W+2)'(term(prod_r[c][3], ng_r[c][3]));
        // out of range when the bits above the word disagree with the sign
        if ((&top) || !(|top)) begin
          r_r[c]   <= acc[FRACTION_BITS+WORD_BITS-1:FRACTION_BITS];
          sat_r[c] <= 1'b0;
        end else begin
          r_r[c]   <= acc[ACC_W-1] ? WORD_MIN : WORD_MAX;
          sat_r[c] <= 1'b1;
        end
      end
    end
  end

  assign r   = r_r;
  assign sat = sat_r;

endmodule

@@ sv/qru_norm.sv @@
// normalize pipeline: sum of squares, one root bit per stage, one quotient bit per stage
// depends on qru_pkg
module qru_norm import qru_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  quat_t a,
  output quat_t r,
  output logic  sat,
  output logic  zero
);

  localparam int RAD_W  = 2 * WORD_BITS + 2;
  localparam int ROOT_W = WORD_BITS + 1;
  localparam int REM_W  = WORD_BITS + 5;
  localparam int DREM_W = WORD_BITS + 2;
  localparam int Q_W    = FRACTION_BITS + 1;
  localparam int V_W    = Q_W + 2;

  typedef logic [3:0][WORD_BITS-1:0] mags_t;

  // front: squares and sums
  mags_t             mag0_r, mag1_r, mag2_r;
  logic [3:0]        neg0_r, neg1_r, neg2_r;
  logic [PROD_W-1:0] sq_r [4];
  logic [PROD_W:0]   s01_r, s23_r;
  logic [RAD_W-1:0]  s_r;
  logic              zero2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mag0_r[i] <= a[i][WORD_BITS-1] ? WORD_BITS'(-a[i]) : WORD_BITS'(a[i]);
        neg0_r[i] <= a[i][WORD_BITS-1];
        sq_r[i]   <= a[i] * a[i];
      end
      s01_r   <= (PROD_W+1)'(sq_r[0]) + (PROD_W+1)'(sq_r[1]);
      s23_r   <= (PROD_W+1)'(sq_r[2]) + (PROD_W+1)'(sq_r[3]);
      mag1_r  <= mag0_r;
      neg1_r  <= neg0_r;
      s_r     <= RAD_W'(s01_r) + RAD_W'(s23_r);
      zero2_r <= (s01_r == '0) && (s23_r == '0);
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
    end
  end

  // square root, two radicand bits per stage
  logic [REM_W-1:0]  rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_r [SQRT_STEPS];
  logic [RAD_W-1:0]  rad_r  [SQRT_STEPS];
  mags_t             smag_r [SQRT_STEPS];
  logic [3:0]        sneg_r [SQRT_STEPS];
  logic              szero_r[SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
    logic [REM_W-1:0]  rem_in, cur, trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    mags_t             mag_in;
    logic [3:0]        neg_in;
    logic              zero_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = s_r;
      assign mag_in  = mag2_r;
      assign neg_in  = neg2_r;
      assign zero_in = zero2_r;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign mag_in  = smag_r[k-1];
      assign neg_in  = sneg_r[k-1];
      assign zero_in = szero_r[k-1];
    end

    always_comb begin
      cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial = REM_W'({root_in, 2'b01});
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]   <= ge ? cur - trial : cur;
        root_r[k]  <= {root_in[ROOT_W-2:0], ge};
        rad_r[k]   <= {rad_in[RAD_W-3:0], 2'b00};
        smag_r[k]  <= mag_in;
        sneg_r[k]  <= neg_in;
        szero_r[k] <= zero_in;
      end
    end
  end

  // restoring divide of |a| * 2^F by the length; |a| never exceeds the length
  logic [DREM_W-1:0] drem_r [DIV_STEPS][4];
  logic [Q_W-1:0]    q_r    [DIV_STEPS][4];
  logic [ROOT_W-1:0] len_r  [DIV_STEPS];
  logic [3:0]        dneg_r [DIV_STEPS];
  logic              dzero_r[DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [ROOT_W-1:0] len_in;
    logic [3:0]        neg_in;
    logic              zero_in;
    logic [DREM_W-1:0] dlen;

    if (j == 0) begin : g_first
      assign len_in  = root_r[SQRT_STEPS-1];
      assign neg_in  = sneg_r[SQRT_STEPS-1];
      assign zero_in = szero_r[SQRT_STEPS-1];
    end else begin : g_next
      assign len_in  = len_r[j-1];
      assign neg_in  = dneg_r[j-1];
      assign zero_in = dzero_r[j-1];
    end

    assign dlen = DREM_W'(len_in);

    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [DREM_W-1:0] cur;
      logic [Q_W-1:0]    q_in;
      logic              ge;

      if (j == 0) begin : g_first
        assign cur  = DREM_W'(smag_r[SQRT_STEPS-1][i]);
        assign q_in = '0;
      end else begin : g_next
        assign cur  = {drem_r[j-1][i][DREM_W-2:0], 1'b0};
        assign q_in = q_r[j-1][i];
      end

      assign ge = cur >= dlen;

      always_ff @(posedge clk) begin
        if (en) begin
          drem_r[j][i] <= ge ? cur - dlen : cur;
          q_r[j][i]    <= {q_in[Q_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[j]   <= len_in;
        dneg_r[j]  <= neg_in;
        dzero_r[j] <= zero_in;
      end
    end
  end

  // round half away from zero, apply sign, clamp
  quat_t      r_r;
  logic [3:0] lsat;
  logic       sat_r, zero_r;
  word_t      lval [4];

  for (genvar i = 0; i < 4; i++) begin : g_out
    logic [DREM_W-1:0]     dlen, twice;
    logic [Q_W:0]          qr;
    logic signed [V_W-1:0] v;

    always_comb begin
      dlen  = DREM_W'(len_r[DIV_STEPS-1]);
      twice = {drem_r[DIV_STEPS-1][i][DREM_W-2:0], 1'b0};
      qr    = (Q_W+1)'(q_r[DIV_STEPS-1][i]) + (Q_W+1)'(twice >= dlen);
      v     = dneg_r[DIV_STEPS-1][i] ? -V_W'(qr) : V_W'(qr);
    end

    if (V_W > WORD_BITS) begin : g_clamp
      logic [V_W-WORD_BITS:0] top;
      assign top = v[V_W-1:WORD_BITS-1];
      always_comb begin
        if ((&top) || !(|top)) begin
          lval[i] = v[WORD_BITS-1:0];
          lsat[i] = 1'b0;
        end else begin
          lval[i] = v[V_W-1] ? WORD_MIN : WORD_MAX;
          lsat[i] = 1'b1;
        end
      end
    end else begin : g_fit
      assign lval[i] = WORD_BITS'(v);
      assign lsat[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        r_r[i] <= lval[i];
      end
      sat_r  <= |lsat;
      zero_r <= dzero_r[DIV_STEPS-1];
    end
  end

  assign r    = r_r;
  assign sat  = sat_r;
  assign zero = zero_r;

endmodule

@@ sv/quaternion_rotation_unit_top.sv @@
// Quaternion arithmetic unit (multiply, conjugate, normalize, rotate) in Q3.28 fixed point.
// One item is accepted every cycle while the output is not stalled; the depth is set by the
// normalize path, a 33-stage square root followed by a 29-stage divider and a
// rounding stage. Multiply uses one 3-stage product unit and rotate two; all are delayed
// to the same depth, so results leave in order. A stalled output freezes the whole pipeline.
// depends on qru_pkg, qru_ifs, qru_mul, qru_norm and the assertion macro header
`include "quaternion_rotation_unit_top_assert.svh"

module quaternion_rotation_unit_top import qru_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  qru_in_if.sink    in_ch,
  qru_out_if.source out_ch
);

  localparam int TAIL = NORM_LAT - 2 * MUL_LAT;

  logic              en;
  logic [NORM_LAT-1:0] vld_r;
  op_t               op_r   [NORM_LAT];
  quat_t             a_r    [MUL_LAT];
  res_t              fast_r [MUL_LAT];
  res_t              tail_r [TAIL];
  quat_t             out_q_r;
  status_t           out_st_r;
  logic              out_valid_r;

  quat_t      a_in, b_in, v_in, p1, q1, r1, r2, rn;
  logic       rot_in;
  logic [3:0] s1, s2;
  logic       sn, zn;
  res_t       fast3, fast6;
  quat_t      fin_q;
  status_t    fin_st;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    a_in   = {in_ch.a_w, in_ch.a_z, in_ch.a_y, in_ch.a_x};
    b_in   = {in_ch.b_w, in_ch.b_z, in_ch.b_y, in_ch.b_x};
    v_in   = {word_t'(0), in_ch.b_z, in_ch.b_y, in_ch.b_x};
    rot_in = in_ch.opcode == OP_ROT;
    // rotate first forms v * conj(a)
    p1     = rot_in ? v_in : a_in;
    q1     = rot_in ? a_in : b_in;
  end

  qru_mul u_mul1 (
    .clk    (clk),
    .en     (en),
    .p      (p1),
    .q      (q1),
    .conj_q (rot_in),
    .r      (r1),
    .sat    (s1)
  );

  qru_mul u_mul2 (
    .clk    (clk),
    .en     (en),
    .p      (a_r[MUL_LAT-1]),
    .q      (r1),
    .conj_q (1'b0),
    .r      (r2),
    .sat    (s2)
  );

  qru_norm u_norm (
    .clk  (clk),
    .en   (en),
    .a    (a_in),
    .r    (rn),
    .sat  (sn),
    .zero (zn)
  );

  always_comb begin
    fast3.q   = '0;
    fast3.sat = 1'b0;
    case (op_r[MUL_LAT-1])
      OP_MUL: begin
        fast3.q   = r1;
        fast3.sat = |s1;
      end
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) begin
          if (a_r[MUL_LAT-1][i] == WORD_MIN) begin
            fast3.q[i] = WORD_MAX;
            fast3.sat  = 1'b1;
          end else begin
            fast3.q[i] = -a_r[MUL_LAT-1][i];
          end
        end
        fast3.q[3] = a_r[MUL_LAT-1][3];
      end
      OP_ROT: begin
        fast3.sat = |s1;
      end
      default: begin
        fast3.q   = '0;
        fast3.sat = 1'b0;
      end
    endcase
  end

  always_comb begin
    fast6 = fast_r[MUL_LAT-1];
    if (op_r[2*MUL_LAT-1] == OP_ROT) begin
      fast6.q   = {word_t'(0), r2[2], r2[1], r2[0]};
      fast6.sat = fast_r[MUL_LAT-1].sat || (|s2[2:0]);
    end
  end

  always_comb begin
    fin_q  = tail_r[TAIL-1].q;
    fin_st = tail_r[TAIL-1].sat ? ST_SAT : ST_OK;
    case (op_r[NORM_LAT-1])
      OP_NORM: begin
        if (zn) begin
          fin_q  = '0;
          fin_st = ST_ZERO;
        end else begin
          fin_q  = rn;
          fin_st = sn ? ST_SAT : ST_OK;
        end
      end
      default: begin
        fin_q  = tail_r[TAIL-1].q;
        fin_st = tail_r[TAIL-1].sat ? ST_SAT : ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NORM_LAT-2:0], in_ch.valid};
      out_valid_r <= vld_r[NORM_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0]   <= op_t'(in_ch.opcode);
      a_r[0]    <= a_in;
      fast_r[0] <= fast3;
      tail_r[0] <= fast6;
      for (int k = 1; k < NORM_LAT; k++) begin
        op_r[k] <= op_r[k-1];
      end
      for (int k = 1; k < MUL_LAT; k++) begin
        a_r[k]    <= a_r[k-1];
        fast_r[k] <= fast_r[k-1];
      end
      for (int k = 1; k < TAIL; k++) begin
        tail_r[k] <= tail_r[k-1];
      end
      out_q_r  <= fin_q;
      out_st_r <= fin_st;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.r_x    = out_q_r[0];
  assign out_ch.r_y    = out_q_r[1];
  assign out_ch.r_z    = out_q_r[2];
  assign out_ch.r_w    = out_q_r[3];
  assign out_ch.status = out_st_r;

  `QRU_ASSERT_IMP(a_zero_len, out_valid_r && (out_st_r == ST_ZERO), out_q_r == '0, "zero-length result not cleared")
  `QRU_ASSERT_NXT(a_frozen, !en, $stable(vld_r) && $stable(out_valid_r), "pipeline moved during a stall")
  `QRU_ASSERT_NXT(a_enter, en, vld_r[0] == $past(in_ch.valid), "accepted item did not enter the pipeline")

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the quaternion rotation unit: directed table, then random items
// depends on qru_pkg, qru_ifs and quaternion_rotation_unit_top
`timescale 1ns / 100ps

module tb_top;
  import qru_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef wide_t wq_t [4];

  typedef struct {
    op_t     op;
    quat_t   a;
    quat_t   b;
    bit      typed;
    quat_t   r;
    status_t st;
  } qitem_t;

  typedef struct {
    quat_t   r;
    status_t st;
  } qres_t;

  localparam int    CYCLE_LIMIT = 600000;
  localparam int    N_RANDOM    = 1880;
  localparam int    HOLD_CYCLES = 300;
  localparam word_t ONE         = word_t'(1) <<< FRACTION_BITS;
  localparam wide_t W_HI        = WORD_MAX;
  localparam wide_t W_LO        = WORD_MIN;

  logic clk = 1'b0;
  logic rst_n;

  qru_in_if  in_ch();
  qru_out_if out_ch();

  quaternion_rotation_unit_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  qres_t  pending_results[$];
  qitem_t table_rows[$];
  qitem_t cur_item;
  int     n_errors;
  int     n_checked;
  int     op_count[4];
  int     cycles;
  bit     hold_req;
  bit     done;

  // ---------------- predictor ----------------
  function automatic word_t clamp_word(input wide_t v, inout bit sat);
    if (v > W_HI) begin
      sat = 1'b1;
      return WORD_MAX;
    end else if (v < W_LO) begin
      sat = 1'b1;
      return WORD_MIN;
    end
    return word_t'(v);
  endfunction

  function automatic word_t round_word(input wide_t acc, inout bit sat);
    wide_t t;
    t = (acc + (wide_t'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    return clamp_word(t, sat);
  endfunction

  // hamilton product p*q, index 0..2 vector, 3 scalar; sat per component
  function automatic void hamilton(input wq_t p, input wq_t q, output quat_t r,
                                   output bit s[4]);
    wide_t acc[4];
    acc[0] = p[3]*q[0] + p[0]*q[3] + p[1]*q[2] - p[2]*q[1];
    acc[1] = p[3]*q[1] - p[0]*q[2] + p[1]*q[3] + p[2]*q[0];
    acc[2] = p[3]*q[2] + p[0]*q[1] - p[1]*q[0] + p[2]*q[3];
    acc[3] = p[3]*q[3] - p[0]*q[0] - p[1]*q[1] - p[2]*q[2];
    for (int c = 0; c < 4; c++) begin
      s[c] = 1'b0;
      r[c] = round_word(acc[c], s[c]);
    end
  endfunction

  function automatic logic [127:0] int_sqrt(input logic [127:0] v);
    logic [127:0] res, cand;
    res = '0;
    for (int i = 33; i >= 0; i--) begin
      cand = res | (128'd1 << i);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  function automatic qres_t predict_quat(input qitem_t it);
    qres_t        o;
    wq_t          pa, pb, pv;
    quat_t        t;
    bit           s[4];
    bit           sat;
    logic [127:0] sum, len, mag, num, quo, rem;
    wide_t        sv;
    sat = 1'b0;
    o.r = '0;
    o.st = ST_OK;
    for (int i = 0; i < 4; i++) begin
      pa[i] = it.a[i];
      pb[i] = it.b[i];
    end
    case (it.op)
      OP_MUL: begin
        hamilton(pa, pb, o.r, s);
        sat = s[0] | s[1] | s[2] | s[3];
      end
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) o.r[i] = clamp_word(-pa[i], sat);
        o.r[3] = it.a[3];
      end
      OP_NORM: begin
        sum = '0;
        for (int i = 0; i < 4; i++) sum += pa[i] * pa[i];
        if (sum == 0) begin
          o.st = ST_ZERO;
        end else begin
          len = int_sqrt(sum);
          for (int i = 0; i < 4; i++) begin
            mag = (pa[i] < 0) ? -pa[i] : pa[i];
            num = mag << FRACTION_BITS;
            quo = num / len;
            rem = num % len;
            if (2 * rem >= len) quo++;
            sv = (pa[i] < 0) ? -wide_t'(quo) : wide_t'(quo);
            o.r[i] = clamp_word(sv, sat);
          end
        end
      end
      default: begin
        // t = v * conj(a) is rounded to words before the second product
        pv[0] = pb[0];
        pv[1] = pb[1];
        pv[2] = pb[2];
        pv[3] = 0;
        pb[0] = -pa[0];
        pb[1] = -pa[1];
        pb[2] = -pa[2];
        pb[3] = pa[3];
        hamilton(pv, pb, t, s);
        sat = s[0] | s[1] | s[2] | s[3];
        for (int i = 0; i < 4; i++) pv[i] = t[i];
        hamilton(pa, pv, o.r, s);
        sat = sat | s[0] | s[1] | s[2];
        o.r[3] = '0;
      end
    endcase
    if (o.st == ST_OK && sat) o.st = ST_SAT;
    return o;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    qres_t e;
    quat_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (cur_item.typed) begin
          e.r = cur_item.r;
          e.st = cur_item.st;
        end else begin
          e = predict_quat(cur_item);
        end
        pending_results.push_back(e);
        op_count[cur_item.op]++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", out_ch.status, '0);
        end else begin
          e = pending_results.pop_front();
          got = '{out_ch.r_w, out_ch.r_z, out_ch.r_y, out_ch.r_x};
          for (int i = 0; i < 4; i++)
            if (got[i] !== e.r[i]) report_mismatch($sformatf("r[%0d]", i), got[i], e.r[i]);
          if (out_ch.status !== e.st) report_mismatch("status", out_ch.status, e.st);
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- result side ----------------
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        // long hold-off so the pipeline fills and back-pressures the input
        out_ch.ready <= 1'b0;
        hold = 0;
        while (hold < HOLD_CYCLES) begin
          @(posedge clk);
          hold++;
        end
        hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else if ($urandom_range(0, 99) < 20) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------- input side ----------------
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return word_t'($urandom());
      1:       return WORD_MAX;
      2:       return WORD_MIN;
      3:       return '0;
      4:       return $urandom_range(0, 1) ? ONE : -ONE;
      default: return word_t'($signed($urandom_range(0, 32'h3fff_ffff)) - 32'sh2000_0000);
    endcase
  endfunction

  function automatic qitem_t rand_item();
    qitem_t it;
    it.op = op_t'($urandom_range(0, 3));
    it.typed = 1'b0;
    it.r = '0;
    it.st = ST_OK;
    for (int i = 0; i < 4; i++) begin
      it.a[i] = rand_word();
      it.b[i] = rand_word();
    end
    // an all-zero normalize now and then
    if (it.op == OP_NORM && $urandom_range(0, 29) == 0) it.a = '0;
    return it;
  endfunction

  function automatic void add_row(input op_t op, input quat_t a, input quat_t b,
                                  input bit typed, input quat_t r, input status_t st);
    qitem_t it;
    it.op = op;
    it.a = a;
    it.b = b;
    it.typed = typed;
    it.r = r;
    it.st = st;
    table_rows.push_back(it);
  endfunction

  task automatic send_item(input qitem_t it);
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= it.op;
    in_ch.a_x <= it.a[0];
    in_ch.a_y <= it.a[1];
    in_ch.a_z <= it.a[2];
    in_ch.a_w <= it.a[3];
    in_ch.b_x <= it.b[0];
    in_ch.b_y <= it.b[1];
    in_ch.b_z <= it.b[2];
    in_ch.b_w <= it.b[3];
    cur_item <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_gap();
    int g;
    g = $urandom_range(0, 99);
    if (g < 70) return;
    in_ch.valid <= 1'b0;
    if (g < 97) repeat ($urandom_range(1, 4)) @(posedge clk);
    else repeat ($urandom_range(20, 80)) @(posedge clk);
  endtask

  initial begin
    quat_t z, mx, mn, id;
    qitem_t it;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_MUL;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.a_w} = '0;
    {in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.b_w} = '0;
    hold_req = 1'b0;
    z  = '0;
    mx = '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX};
    mn = '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN};
    id = '{ONE, 32'sd0, 32'sd0, 32'sd0};

    add_row(OP_MUL,  z,  z,  1'b1, z, ST_OK);
    add_row(OP_MUL,  id, mx, 1'b1, mx, ST_OK);
    add_row(OP_MUL,  mx, mx, 1'b0, z, ST_OK);
    add_row(OP_MUL,  mn, mn, 1'b0, z, ST_OK);
    add_row(OP_MUL,  mx, mn, 1'b0, z, ST_OK);
    add_row(OP_CONJ, z,  mx, 1'b1, z, ST_OK);
    add_row(OP_CONJ, mn, z,  1'b1, '{WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX}, ST_SAT);
    add_row(OP_CONJ, mx, z,  1'b1, '{WORD_MAX, -WORD_MAX, -WORD_MAX, -WORD_MAX}, ST_OK);
    add_row(OP_NORM, z,  mx, 1'b1, z, ST_ZERO);
    add_row(OP_NORM, '{32'sd0, 32'sd0, 32'sd0, ONE}, z, 1'b1,
            '{32'sd0, 32'sd0, 32'sd0, ONE}, ST_OK);
    add_row(OP_NORM, '{32'sd0, 32'sd0, 32'sd0, 32'sd1}, z, 1'b0, z, ST_OK);
    add_row(OP_NORM, mx, z, 1'b0, z, ST_OK);
    add_row(OP_NORM, mn, z, 1'b0, z, ST_OK);
    add_row(OP_NORM, '{-ONE, ONE, -ONE, ONE}, z, 1'b0, z, ST_OK);
    add_row(OP_ROT,  id, '{mx[3], 32'sd7, -ONE, ONE}, 1'b0, z, ST_OK);
    add_row(OP_ROT,  z,  mx, 1'b1, z, ST_OK);
    add_row(OP_ROT,  mx, mx, 1'b0, z, ST_OK);
    add_row(OP_ROT,  mn, mx, 1'b0, z, ST_OK);
    add_row(OP_ROT,  '{ONE, 32'sd0, 32'sd0, 32'sd0}, '{32'sd0, 32'sd0, ONE, ONE},
            1'b0, z, ST_OK);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) begin
      send_item(table_rows[i]);
      idle_gap();
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 600) hold_req = 1'b1;
      if (n == 1200) begin
        in_ch.valid <= 1'b0;
        // let the checker log the last accepted item before draining
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      it = rand_item();
      send_item(it);
      // a stretch with no input gaps
      if (n < 300 || n > 400) idle_gap();
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("checked %0d results: %0d multiply, %0d conjugate, %0d normalize, %0d rotate",
             n_checked, op_count[OP_MUL], op_count[OP_CONJ], op_count[OP_NORM],
             op_count[OP_ROT]);
    $display("covered field extremes, saturation, zero-length normalize and back-pressure");
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ quaternion_rotation_unit_top.f @@
+incdir+sv
sv/qru_pkg.sv
sv/qru_ifs.sv
sv/qru_mul.sv
sv/qru_norm.sv
sv/quaternion_rotation_unit_top.sv
bench/tb_top.sv
